// ===== rtl/core/cflrc_pkg.sv =====
// Shared types, constants and the CRC step function for the log record checker.
`timescale 1ns / 1ps

package cflrc_pkg;

    localparam int          TX_SLOTS_DEF = 64;
    localparam int          QUEUE_DEPTH  = 4;
    localparam int          LEN_W        = 21;
    localparam logic [20:0] BODY_CAP     = 21'd1048576;
    localparam logic [31:0] HEADER_BYTES = 32'd20;
    localparam logic [31:0] STAGE_TOP    = 32'd6;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] REC_MAGIC    = 32'h31464356;

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_ACCEPT  = 3'd1;
    localparam logic [2:0] KIND_QUAR    = 3'd2;
    localparam logic [2:0] KIND_FULL    = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_log;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [63:0] record_sequence;
        logic [63:0] transaction_id;
        logic [2:0]  stage_number;
        logic        log_done;
    } result_t;

    // Word from the parser to the checker: a ready result or a record to check
    typedef struct packed {
        logic    check;
        logic    pre_ok;
        logic    clear;
        result_t res;
    } cmd_t;

    // Reflected CRC-32 over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] x;
        x = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

endpackage

// ===== rtl/core/cflrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cflrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/cflrc_front.sv =====
// Byte parser: frames records, runs the CRC, captures the header, emits words.
`timescale 1ns / 1ps

module cflrc_front
    import cflrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  item_t            item,
    input  logic             back_halt,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    output logic             cmd_push,
    output cmd_t             cmd
);

    localparam logic [1:0] PH_MAGIC  = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_CRC    = 2'd3;

    logic             halt_reg, halt_next;
    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      acc_reg, acc_next;
    logic [63:0]      seq_reg, seq_next;
    logic [63:0]      tx_reg, tx_next;
    logic [31:0]      stage_reg, stage_next;
    logic [LEN_W-1:0] max_len_reg;

    logic [31:0]      word;
    logic [LEN_W:0]   count_inc;
    logic [LEN_W-1:0] limit;
    logic             quar;

    assign word      = {item.data_byte, acc_reg[31:8]};
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign limit     = (max_len_reg > BODY_CAP) ? BODY_CAP : max_len_reg;

    // Parse one item
    always_comb
    begin
        halt_next  = halt_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        acc_next   = acc_reg;
        seq_next   = seq_reg;
        tx_next    = tx_reg;
        stage_next = stage_reg;
        quar       = 1'b0;
        cmd_push   = 1'b0;
        cmd        = '0;
        if (accept && !halt_reg && !back_halt)
        begin
            if (item.has_byte)
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (count_reg[1:0] == 2'd3)
                        begin
                            if (word != REC_MAGIC)
                            begin
                                quar = 1'b1;
                            end
                            phase_next = PH_LENGTH;
                            count_next = '0;
                            acc_next   = '0;
                        end
                        else
                        begin
                            acc_next   = word;
                            count_next = count_inc[LEN_W-1:0];
                        end
                    end
                    PH_LENGTH:
                    begin
                        if (count_reg[1:0] == 2'd3)
                        begin
                            if (word < HEADER_BYTES || word > {11'd0, limit})
                            begin
                                quar = 1'b1;
                            end
                            len_next   = word[LEN_W-1:0];
                            phase_next = PH_BODY;
                            count_next = '0;
                            acc_next   = '0;
                            crc_next   = '1;
                        end
                        else
                        begin
                            acc_next   = word;
                            count_next = count_inc[LEN_W-1:0];
                        end
                    end
                    PH_BODY:
                    begin
                        crc_next = crc_byte(crc_reg, item.data_byte);
                        if (count_reg < LEN_W'(8))
                        begin
                            seq_next = {item.data_byte, seq_reg[63:8]};
                        end
                        else if (count_reg < LEN_W'(16))
                        begin
                            tx_next = {item.data_byte, tx_reg[63:8]};
                        end
                        else if (count_reg < LEN_W'(20))
                        begin
                            stage_next = {item.data_byte, stage_reg[31:8]};
                        end
                        else
                        begin
                            cmd_push             = 1'b1;
                            cmd.res.kind         = KIND_PAYLOAD;
                            cmd.res.payload_byte = item.data_byte;
                        end
                        if (count_inc >= {1'b0, len_reg})
                        begin
                            phase_next = PH_CRC;
                            count_next = '0;
                            acc_next   = '0;
                        end
                        else
                        begin
                            count_next = count_inc[LEN_W-1:0];
                        end
                    end
                    default:
                    begin
                        if (count_reg[1:0] == 2'd3)
                        begin
                            cmd_push                = 1'b1;
                            cmd.check               = 1'b1;
                            cmd.pre_ok              = (word == ~crc_reg) && (tx_reg != '0)
                                                      && (stage_reg >= 32'd1)
                                                      && (stage_reg <= STAGE_TOP);
                            cmd.res.kind            = KIND_ACCEPT;
                            cmd.res.record_sequence = seq_reg;
                            cmd.res.transaction_id  = tx_reg;
                            cmd.res.stage_number    = stage_reg[2:0];
                            phase_next              = PH_MAGIC;
                            count_next              = '0;
                            acc_next                = '0;
                        end
                        else
                        begin
                            acc_next   = word;
                            count_next = count_inc[LEN_W-1:0];
                        end
                    end
                endcase
            end
            // End marker: clean only on a record boundary
            if (item.end_of_log && !quar)
            begin
                if (phase_next == PH_MAGIC && count_next == '0)
                begin
                    if (cmd.check)
                    begin
                        cmd.res.log_done = 1'b1;
                    end
                    else
                    begin
                        cmd_push     = 1'b1;
                        cmd          = '0;
                        cmd.clear    = 1'b1;
                        cmd.res.kind = KIND_END;
                    end
                    acc_next = '0;
                end
                else
                begin
                    quar = 1'b1;
                end
            end
            if (quar)
            begin
                halt_next    = 1'b1;
                cmd_push     = 1'b1;
                cmd          = '0;
                cmd.res.kind = KIND_QUAR;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_reg    <= 1'b0;
            phase_reg   <= PH_MAGIC;
            count_reg   <= '0;
            acc_reg     <= '0;
            max_len_reg <= BODY_CAP;
        end
        else
        begin
            halt_reg  <= halt_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    // Record payload registers
    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        crc_reg   <= crc_next;
        seq_reg   <= seq_next;
        tx_reg    <= tx_next;
        stage_reg <= stage_next;
    end

endmodule

// ===== rtl/core/cflrc_queue.sv =====
// Short word queue between the parser and the record checker.
`timescale 1ns / 1ps

module cflrc_queue
    import cflrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic not_empty,
    output logic is_full
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          slot_q [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   cnt_reg;

    assign not_empty = (cnt_reg != '0);
    assign is_full   = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign rd_data   = slot_q[rptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(wr_en) - (PW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_q[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/cflrc_back.sv =====
// Record checker: sequence check, transaction table search and result register.
`timescale 1ns / 1ps

module cflrc_back
    import cflrc_pkg::*;
#(
    parameter int TX_SLOTS = TX_SLOTS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    halt,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    localparam int IDX_W  = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
    localparam int USED_W = $clog2(TX_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DEC  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              halt_reg, halt_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [63:0]       last_reg, last_next;
    logic              found_reg, found_next;
    logic [2:0]        prior_reg, prior_next;

    logic              out_free;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [66:0]       ram_rdata;

    assign out_free = !out_valid_reg || pop;
    assign halt     = halt_reg;
    assign result   = out_reg;
    assign empty    = !out_valid_reg;

    cflrc_ram #(
        .WIDTH (67),
        .DEPTH (TX_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({cmd.res.transaction_id, cmd.res.stage_number}),
        .re    (state_reg == ST_READ),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        halt_next      = halt_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        last_next      = last_reg;
        found_next     = found_reg;
        prior_next     = prior_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = found_reg ? idx_reg : used_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (halt_reg)
                    begin
                        cmd_pop = 1'b1;
                    end
                    else if (!cmd.check)
                    begin
                        if (out_free)
                        begin
                            cmd_pop        = 1'b1;
                            out_valid_next = 1'b1;
                            out_next       = cmd.res;
                            if (cmd.res.kind == KIND_QUAR)
                            begin
                                halt_next = 1'b1;
                            end
                            if (cmd.clear)
                            begin
                                used_next = '0;
                                last_next = '0;
                            end
                        end
                    end
                    else if (!cmd.pre_ok || cmd.res.record_sequence != last_reg + 64'd1)
                    begin
                        if (out_free)
                        begin
                            cmd_pop        = 1'b1;
                            out_valid_next = 1'b1;
                            out_next       = '0;
                            out_next.kind  = KIND_QUAR;
                            halt_next      = 1'b1;
                        end
                    end
                    else if (used_reg == '0)
                    begin
                        found_next = 1'b0;
                        prior_next = '0;
                        state_next = ST_DEC;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (ram_rdata[66:3] == cmd.res.transaction_id)
                begin
                    found_next = 1'b1;
                    prior_next = ram_rdata[2:0];
                    state_next = ST_DEC;
                end
                else if (USED_W'(idx_reg) + USED_W'(1) < used_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    found_next = 1'b0;
                    prior_next = '0;
                    state_next = ST_DEC;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    cmd_pop        = 1'b1;
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (prior_reg + 3'd1 != cmd.res.stage_number)
                    begin
                        out_next.kind = KIND_QUAR;
                        halt_next     = 1'b1;
                    end
                    else if (!found_reg && used_reg >= USED_W'(TX_SLOTS))
                    begin
                        out_next.kind = KIND_FULL;
                        halt_next     = 1'b1;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        out_next = cmd.res;
                        if (!found_reg)
                        begin
                            used_next = used_reg + 1'b1;
                        end
                        last_next = cmd.res.record_sequence;
                        if (cmd.res.log_done)
                        begin
                            used_next = '0;
                            last_next = '0;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        prior_reg <= prior_next;
    end

endmodule

// ===== rtl/core/crc_framed_log_record_checker_top.sv =====
// Top level of the CRC-framed log record checker.
//
// Input: one log word per push (has_byte, data_byte, end_of_log); a word is
// taken when push is high and full is low. Results come out as a queue:
// while empty is low the oldest result is on result, and pop takes it.
// The parser handles one byte per cycle while full is low and the block is
// not halted; payload bytes pass through the queue and the result register
// to the result port. At the last CRC byte a record is checked by a table
// search that reads and compares the used transaction slots one by one;
// a four-word queue lets the parser run ahead during that search.
// Reset clears the parser, the table fill count and the last sequence; the
// length limit returns to 1 MiB. A quarantine or a full table halts the
// block until reset; later words are taken and dropped. When the receiver
// holds pop low, the result register and then the queue fill and full rises.
// cfg_we writes max_body_length at once; write it only while idle.
`timescale 1ns / 1ps

module crc_framed_log_record_checker_top
    import cflrc_pkg::*;
#(
    parameter int TX_SLOTS = TX_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  item_t            log_item,
    output logic             empty,
    input  logic             pop,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    logic cmd_push, cmd_pop, cmd_valid, back_halt;
    cmd_t cmd_in, cmd_out;

    cflrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push && !full),
        .item      (log_item),
        .back_halt (back_halt),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    cflrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_push),
        .wr_data   (cmd_in),
        .rd_en     (cmd_pop),
        .rd_data   (cmd_out),
        .not_empty (cmd_valid),
        .is_full   (full)
    );

    cflrc_back #(
        .TX_SLOTS (TX_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .halt      (back_halt),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

`ifndef SYNTHESIS
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_ACCEPT) |->
        (result.stage_number >= 3'd1 && result.stage_number <= 3'd6))
        else $error("accepted record with stage out of range");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.log_done) |-> (result.kind == KIND_ACCEPT))
        else $error("log_done on a result that is not an accepted record");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && (result.kind == KIND_QUAR || result.kind == KIND_FULL))
        |=> empty)
        else $error("result after the block halted");
`endif

endmodule
